/* rtl/uart_receiver_with_fifo_unit_macros.svh */
// Assertion macros for the UART receiver with FIFO.
// Included by the top level; no other dependencies.
`ifndef UART_RECEIVER_WITH_FIFO_UNIT_MACROS_SVH
`define UART_RECEIVER_WITH_FIFO_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define URF_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define URF_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/urf_pkg.sv */
// Shared types, codes and constants for the UART receiver with FIFO.
// No dependencies.
package urf_pkg;

  localparam int FIFO_DEPTH = 64;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = (PTR_W > 6) ? PTR_W : 6;

  // result queue between the pipeline and the output port
  localparam int OQ_DEPTH = 3;
  localparam int OQ_W     = 2;

  localparam logic [7:0] BIT_PERIOD_RST  = 8'd52;
  localparam logic [7:0] FIRST_DELAY_RST = 8'd52;
  localparam logic       RX_ENABLE_RST   = 1'b1;
  localparam logic [3:0] LAST_DATA_BIT   = 4'd7;
  localparam logic [3:0] DATA_BITS       = 4'd8;

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_READ  = 2'd1,
    ACT_FLUSH = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    CFG_BIT_PERIOD  = 2'd0,
    CFG_FIRST_DELAY = 2'd1,
    CFG_RX_ENABLE   = 2'd2
  } cfg_index_t;

  typedef enum logic {
    RX_IDLE  = 1'b0,
    RX_FRAME = 1'b1
  } rx_state_t;

  typedef struct packed {
    logic       push;
    logic [7:0] push_data;
  } rx_push_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       read_valid;
    logic [5:0] fifo_count;
    logic       rx_busy;
  } result_t;

  function automatic logic [PTR_W-1:0] ring_next(logic [PTR_W-1:0] p);
    return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

endpackage

/* rtl/urf_rx.sv */
// Bit timing and deserializer for the 8N1 receiver, plus its config registers.
// Depends on urf_pkg.
module urf_rx (
  input  logic              clk,
  input  logic              rst,
  input  logic              tick,
  input  logic              level,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [7:0]        cfg_data,
  output urf_pkg::rx_push_t push,
  output logic              busy,
  output logic              busy_next
);
  import urf_pkg::*;

  rx_state_t  state, state_next;
  logic [7:0] countdown, countdown_next;
  logic [3:0] bit_index, bit_index_next;
  logic [7:0] shift_byte, shift_byte_next;
  logic [7:0] bit_period, first_delay;
  logic       rx_enable;
  logic       start, sample;
  logic [7:0] sampled;

  assign start   = tick && (state == RX_IDLE) && rx_enable && !level;
  assign sample  = tick && (state == RX_FRAME) && (countdown <= 8'd1);
  assign sampled = shift_byte | ({7'd0, level} << bit_index[2:0]);

  always_comb begin
    state_next = state;
    case (state)
      RX_IDLE:  if (start) state_next = RX_FRAME;
      RX_FRAME: if (sample && (bit_index >= DATA_BITS)) state_next = RX_IDLE;
      default:  state_next = RX_IDLE;
    endcase
  end

  always_comb begin
    countdown_next  = countdown;
    bit_index_next  = bit_index;
    shift_byte_next = shift_byte;
    push            = '0;
    if (start) begin
      countdown_next  = first_delay;
      bit_index_next  = '0;
      shift_byte_next = '0;
    end else if (tick && (state == RX_FRAME)) begin
      if (!sample) begin
        countdown_next = countdown - 8'd1;
      end else begin
        countdown_next = bit_period;
        if (bit_index < DATA_BITS) begin
          shift_byte_next = sampled;
          bit_index_next  = bit_index + 4'd1;
          if (bit_index == LAST_DATA_BIT) begin
            push.push      = 1'b1;
            push.push_data = sampled;
          end
        end else begin
          bit_index_next = '0;  // stop bit
        end
      end
    end
  end

  assign busy      = (state == RX_FRAME);
  assign busy_next = (state_next == RX_FRAME);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= RX_IDLE;
      countdown  <= '0;
      bit_index  <= '0;
      shift_byte <= '0;
    end else begin
      state      <= state_next;
      countdown  <= countdown_next;
      bit_index  <= bit_index_next;
      shift_byte <= shift_byte_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_period  <= BIT_PERIOD_RST;
      first_delay <= FIRST_DELAY_RST;
      rx_enable   <= RX_ENABLE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BIT_PERIOD:  bit_period  <= cfg_data;
        CFG_FIRST_DELAY: first_delay <= cfg_data;
        CFG_RX_ENABLE:   rx_enable   <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

/* rtl/urf_fifo.sv */
// Receive ring FIFO: byte memory with registered read, and pointers.
// Depends on urf_pkg.
module urf_fifo (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     read,
  input  logic                     flush,
  input  urf_pkg::rx_push_t        push,
  output logic                     empty,
  output logic                     pop_hit,
  output logic [urf_pkg::PTR_W-1:0] count_next,
  output logic [7:0]               rd_data
);
  import urf_pkg::*;

  logic [7:0]       mem [FIFO_DEPTH];
  logic [7:0]       rd_q;
  logic [PTR_W-1:0] wp, rp, wp_next, rp_next, wp_inc;
  logic             full, do_push;

  function automatic logic [PTR_W-1:0] count_of(logic [PTR_W-1:0] w, logic [PTR_W-1:0] r);
    logic [PTR_W:0] sum;
    sum = (w >= r) ? ({1'b0, w} - {1'b0, r})
                   : ((PTR_W+1)'(FIFO_DEPTH) - {1'b0, r} + {1'b0, w});
    return sum[PTR_W-1:0];
  endfunction

  assign wp_inc  = ring_next(wp);
  assign full    = (wp_inc == rp);
  assign empty   = (wp == rp);
  assign do_push = push.push && !full;  // byte dropped when full
  assign pop_hit = read && !empty;

  assign wp_next    = do_push ? wp_inc : wp;
  assign rp_next    = flush ? wp : (pop_hit ? ring_next(rp) : rp);
  assign count_next = count_of(wp_next, rp_next);
  assign rd_data    = rd_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
    end else begin
      wp <= wp_next;
      rp <= rp_next;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wp] <= push.push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (pop_hit) begin
      rd_q <= mem[rp];
    end
  end

endmodule

/* rtl/urf_outq.sv */
// Three-entry result queue that decouples the pipeline from the output stall.
// Depends on urf_pkg.
module urf_outq (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  urf_pkg::result_t        push_item,
  input  logic                    pop,
  output urf_pkg::result_t        head,
  output logic                    valid,
  output logic [urf_pkg::OQ_W-1:0] count
);
  import urf_pkg::*;

  result_t         q [OQ_DEPTH];
  logic [OQ_W-1:0] hd, tl;

  function automatic logic [OQ_W-1:0] wrap_inc(logic [OQ_W-1:0] p);
    return (p == OQ_W'(OQ_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign head  = q[hd];
  assign valid = (count != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      hd    <= '0;
      tl    <= '0;
      count <= '0;
    end else begin
      if (push) tl <= wrap_inc(tl);
      if (pop)  hd <= wrap_inc(hd);
      count <= count + OQ_W'(push) - OQ_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[tl] <= push_item;
    end
  end

endmodule

/* rtl/uart_receiver_with_fifo_unit.sv */
// UART 8N1 receiver with receive FIFO, top level.
// Depends on urf_pkg, urf_rx, urf_fifo, urf_outq and the assertion macro header.
//
// Usage:
//  - Input channel (in_valid/in_stall) carries one transaction per timer tick,
//    read request or flush: action (0 tick, 1 read, 2 flush, 3 no-op) and
//    rx_level, the line level seen at that tick.
//  - Output channel (out_valid/out_stall) returns exactly one transaction per
//    input transaction, in order: read_data/read_valid for reads, plus the
//    FIFO byte count and the receiver busy flag after that transaction.
//  - Config channel (cfg_valid/cfg_ready) writes bit_period (index 0),
//    first_sample_delay (1) and rx_enable (2); cfg_ready is always high.
//    Write only while no transaction is in flight.
// Timing:
//  - One input transaction per clock sustained while out_stall stays low. The
//    FIFO memory has a registered read, so a result passes through the
//    pipeline register, then the result queue, before it reaches the output.
//  - in_stall comes from registers only: it rises once the three-entry result
//    queue and the pipeline register together hold three results.
// Reset: config returns to 52/52/enabled, receiver goes idle, FIFO pointers
//    go empty. The byte memory is not cleared; no clearing pass is needed.
`include "uart_receiver_with_fifo_unit_macros.svh"

module uart_receiver_with_fifo_unit (
  input  logic       clk,
  input  logic       rst,
  // input transactions
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] action,
  input  logic       rx_level,
  // config writes
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  // result transactions
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] read_data,
  output logic       read_valid,
  output logic [5:0] fifo_count,
  output logic       rx_busy
);
  import urf_pkg::*;

  logic             in_accept;
  logic             is_tick, is_read, is_flush;
  rx_push_t         rx_push;
  logic             rx_frame, rx_frame_next;
  logic             fifo_empty, pop_hit;
  logic [PTR_W-1:0] count_next;
  logic [CNT_W-1:0] count_ext;
  logic [7:0]       rd_data;

  // pipeline register: waits for the registered memory read data
  logic             p1_valid;
  logic             p1_read_valid;
  logic [5:0]       p1_count;
  logic             p1_busy;
  result_t          p1_result;

  result_t          q_head;
  logic [OQ_W-1:0]  q_count;
  logic             out_pop;

  assign in_accept = in_valid && !in_stall;
  assign is_tick   = in_accept && (action == ACT_TICK);
  assign is_read   = in_accept && (action == ACT_READ);
  assign is_flush  = in_accept && (action == ACT_FLUSH);
  assign cfg_ready = 1'b1;

  // Credit check on registers only; three slots cover the pipeline register's lag.
  assign in_stall = ({1'b0, q_count} + (OQ_W+1)'(p1_valid)) >= (OQ_W+1)'(OQ_DEPTH);

  urf_rx u_rx (
    .clk       (clk),
    .rst       (rst),
    .tick      (is_tick),
    .level     (rx_level),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (rx_push),
    .busy      (rx_frame),
    .busy_next (rx_frame_next)
  );

  urf_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .read       (is_read),
    .flush      (is_flush),
    .push       (rx_push),
    .empty      (fifo_empty),
    .pop_hit    (pop_hit),
    .count_next (count_next),
    .rd_data    (rd_data)
  );

  assign count_ext = CNT_W'(count_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else begin
      p1_valid <= in_accept;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      p1_read_valid <= pop_hit;
      p1_count      <= count_ext[5:0];
      p1_busy       <= rx_frame_next;
    end
  end

  // memory data lands now; zero unless this transaction read a byte
  always_comb begin
    p1_result.read_data  = p1_read_valid ? rd_data : 8'd0;
    p1_result.read_valid = p1_read_valid;
    p1_result.fifo_count = p1_count;
    p1_result.rx_busy    = p1_busy;
  end

  assign out_pop = out_valid && !out_stall;

  urf_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (p1_valid),
    .push_item (p1_result),
    .pop       (out_pop),
    .head      (q_head),
    .valid     (out_valid),
    .count     (q_count)
  );

  assign read_data  = q_head.read_data;
  assign read_valid = q_head.read_valid;
  assign fifo_count = q_head.fifo_count;
  assign rx_busy    = q_head.rx_busy;

  // queue never receives a result it has no room for
  `URF_ASSERT_IMP(a_oq_no_overflow, clk, rst, (q_count == OQ_W'(OQ_DEPTH)), !p1_valid,
                  "result queue overflow")

  // a read on an empty FIFO never reports a byte
  `URF_ASSERT_NXT(a_empty_read, clk, rst, (is_read && fifo_empty),
                  (p1_valid && !p1_read_valid), "read of empty FIFO returned data")

  // a frame only ends on a tick
  `URF_ASSERT_IMP(a_frame_end_on_tick, clk, rst, $fell(rx_frame), $past(is_tick),
                  "receiver left frame without a tick")

endmodule

/* test/tb_uart_receiver_with_fifo_unit.sv */
// Self-checking testbench for uart_receiver_with_fifo_unit: serial frames, reads and flushes
// go in, per-transaction status is predicted in the bench and compared field by field.
// Depends on urf_pkg and the RTL of the block.
module tb_uart_receiver_with_fifo_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import urf_pkg::*;

  // Action code 3 has no function; the block just reports status.
  localparam logic [1:0]  ACT_NOP       = 2'd3;
  localparam int unsigned CYCLE_LIMIT   = 600000;
  // Settle time after draining, before config writes and at the end.
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned WHOLE_FRAME   = 32'hFFFF_FFFF;

  typedef struct {
    logic [1:0] act;
    logic       lvl;
  } line_item_t;

  logic       clk;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] action = ACT_TICK;
  logic       rx_level = 1'b1;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index = CFG_BIT_PERIOD;
  logic [7:0] cfg_data = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] read_data;
  logic       read_valid;
  logic [5:0] fifo_count;
  logic       rx_busy;

  uart_receiver_with_fifo_unit dut (.*);

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------------
  // Predictor: shadow registers and receiver/FIFO state, advanced once per
  // accepted input transaction.
  // ---------------------------------------------------------------------------
  logic [7:0]       period_sh = BIT_PERIOD_RST;
  logic [7:0]       delay_sh  = FIRST_DELAY_RST;
  logic             enable_sh = RX_ENABLE_RST;
  rx_state_t        rx_state  = RX_IDLE;
  logic [7:0]       tick_cnt  = '0;
  logic [3:0]       bit_pos   = '0;
  logic [7:0]       shift_reg = '0;
  logic [7:0]       ring_mem [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr = '0;
  logic [PTR_W-1:0] rd_ptr = '0;

  line_item_t  pending_line_q[$];
  result_t     expected_status_q[$];

  int unsigned phase_left;
  int unsigned send_gap, send_burst, stall_left, drain_burst;
  int unsigned lines_sent, statuses_checked, mismatch_count, cfg_writes;
  int unsigned bytes_read, bytes_dropped, cycle_count;

  // One timer tick seen by the receiver.
  function automatic void sample_line(logic lvl);
    logic [PTR_W-1:0] nxt;
    nxt = wr_ptr + 1'b1;
    if (rx_state == RX_IDLE) begin
      // start detection only when enabled; the stop-sample tick never gets here
      if (enable_sh && !lvl) begin
        rx_state  = RX_FRAME;
        tick_cnt  = delay_sh;
        bit_pos   = '0;
        shift_reg = '0;
      end
    end else if (tick_cnt > 8'd1) begin
      tick_cnt = tick_cnt - 1'b1;
    end else begin
      // a loaded zero falls through here on the next tick, same as one
      tick_cnt = period_sh;
      if (bit_pos < DATA_BITS) begin
        shift_reg[bit_pos[2:0]] = lvl;
        if (bit_pos == LAST_DATA_BIT) begin
          if (nxt != rd_ptr) begin
            ring_mem[wr_ptr] = shift_reg;
            wr_ptr = nxt;
          end else begin
            bytes_dropped++;
          end
        end
        bit_pos = bit_pos + 1'b1;
      end else begin
        // stop bit: its level is not checked
        rx_state = RX_IDLE;
        bit_pos  = '0;
      end
    end
  endfunction

  function automatic result_t predict_status(logic [1:0] act, logic lvl);
    result_t r;
    r = '0;
    case (act)
      ACT_TICK: sample_line(lvl);
      ACT_READ: begin
        if (wr_ptr != rd_ptr) begin
          r.read_data  = ring_mem[rd_ptr];
          r.read_valid = 1'b1;
          rd_ptr = rd_ptr + 1'b1;
          bytes_read++;
        end
      end
      ACT_FLUSH: rd_ptr = wr_ptr;
      default: ;
    endcase
    r.fifo_count = wr_ptr - rd_ptr;
    r.rx_busy    = (rx_state == RX_FRAME);
    return r;
  endfunction

  // Gap length for either side: mostly none or short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // ---------------------------------------------------------------------------
  // Input driver: pops pending line transactions, predicts at acceptance.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : drive_lines
    line_item_t item;
    if (rst) begin
      in_valid <= 1'b0;
      action   <= ACT_TICK;
      rx_level <= 1'b1;
      send_gap = 0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_status_q.push_back(predict_status(action, rx_level));
        lines_sent++;
      end
      // payload only moves once the current transaction is gone
      if (!in_valid || !in_stall) begin
        if (send_gap != 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_line_q.size() != 0) begin
          item = pending_line_q.pop_front();
          action   <= item.act;
          rx_level <= item.lvl;
          in_valid <= 1'b1;
          if (send_burst != 0) begin
            send_burst--;
          end else if ($urandom_range(0, 99) == 0) begin
            send_burst = $urandom_range(30, 120);
          end else begin
            send_gap = pick_gap();
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output monitor: random stalls, in-order compare against expectations.
  // ---------------------------------------------------------------------------
  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin : check_status
    result_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_status_q.size() == 0) begin
          $error("result transaction with no expectation pending");
          mismatch_count++;
        end else begin
          want = expected_status_q.pop_front();
          statuses_checked++;
          check_field("read_data", want.read_data, read_data);
          check_field("read_valid", want.read_valid, read_valid);
          check_field("fifo_count", want.fifo_count, fifo_count);
          check_field("rx_busy", want.rx_busy, rx_busy);
        end
      end
      if (stall_left != 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        if (drain_burst != 0) begin
          drain_burst--;
        end else if ($urandom_range(0, 99) == 0) begin
          drain_burst = $urandom_range(30, 120);
        end else begin
          stall_left = pick_gap();
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_status_q.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic queue_line(logic [1:0] act, logic lvl);
    line_item_t it;
    it.act = act;
    it.lvl = lvl;
    pending_line_q.push_back(it);
    if (phase_left != 0) phase_left--;
  endtask

  // Reads, flushes and the odd no-op between ticks; none of them moves the timer.
  task automatic sprinkle(int unsigned rd_pct, int unsigned fl_pct);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < rd_pct) queue_line(ACT_READ, 1'($urandom_range(0, 1)));
    else if (r < rd_pct + fl_pct) queue_line(ACT_FLUSH, 1'($urandom_range(0, 1)));
    else if (r == 99) queue_line(ACT_NOP, 1'($urandom_range(0, 1)));
  endtask

  // One 8N1 frame as a line waveform, one level per tick, laid out against the
  // current timing so every sample tick sees the intended bit. cut truncates
  // the frame for broken sequences; the phase budget truncates it as well.
  task automatic gen_frame(logic [7:0] data, logic stop_lvl, int unsigned cut,
                           int unsigned rd_pct, int unsigned fl_pct);
    int unsigned d, p, span, k;
    d = (delay_sh == 0) ? 1 : delay_sh;
    p = (period_sh == 0) ? 1 : period_sh;
    span = d + DATA_BITS * p;
    for (int unsigned t = 0; t <= span && t < cut && phase_left != 0; t++) begin
      k = (t <= d) ? 0 : (t - d - 1) / p + 1;
      if (t == 0) queue_line(ACT_TICK, 1'b0);
      else if (k < DATA_BITS) queue_line(ACT_TICK, data[k]);
      else queue_line(ACT_TICK, stop_lvl);
      sprinkle(rd_pct, fl_pct);
    end
  endtask

  task automatic write_reg(cfg_index_t idx, logic [7:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_BIT_PERIOD:  period_sh = val;
      CFG_FIRST_DELAY: delay_sh  = val;
      default:         enable_sh = val[0];
    endcase
    cfg_writes++;
  endtask

  task automatic set_config(logic [7:0] period, logic [7:0] delay, logic [7:0] enable_raw);
    write_reg(CFG_BIT_PERIOD, period);
    write_reg(CFG_FIRST_DELAY, delay);
    write_reg(CFG_RX_ENABLE, enable_raw);
  endtask

  // Sender holds off until the queue is empty, the last transaction is taken and
  // every expected result has come back.
  task automatic wait_drained();
    do @(posedge clk); while (pending_line_q.size() != 0);
    do @(posedge clk); while (in_valid || expected_status_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One configuration phase: mostly clean frames with random bytes, the rest
  // truncated frames and line noise with random actions.
  task automatic run_phase(logic [7:0] period, logic [7:0] delay, logic [7:0] enable_raw,
                           int unsigned frame_pct, int unsigned rd_pct,
                           int unsigned fl_pct, int unsigned budget);
    int unsigned r;
    wait_drained();
    set_config(period, delay, enable_raw);
    phase_left = budget;
    while (phase_left != 0) begin
      r = $urandom_range(0, 99);
      if (r < frame_pct) begin
        gen_frame(8'($urandom), ($urandom_range(0, 9) == 0) ? 1'b0 : 1'b1, WHOLE_FRAME,
                  rd_pct, fl_pct);
      end else if (r < frame_pct + (100 - frame_pct) / 2) begin
        gen_frame(8'($urandom), 1'($urandom_range(0, 1)), $urandom_range(1, 12),
                  rd_pct, fl_pct);
      end else begin
        repeat ($urandom_range(1, 8))
          queue_line(2'($urandom_range(ACT_TICK, ACT_NOP)), 1'($urandom_range(0, 1)));
      end
      // idle line between frames; zero idle lets a start follow the stop sample
      repeat ($urandom_range(0, 2)) queue_line(ACT_TICK, 1'b1);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: status-only actions at reset timing, no frame started.
    phase_left = 64;
    queue_line(ACT_READ, 1'b0);     // read on empty FIFO
    queue_line(ACT_FLUSH, 1'b1);
    queue_line(ACT_NOP, 1'b0);
    queue_line(ACT_NOP, 1'b1);
    queue_line(ACT_TICK, 1'b1);     // idle line, no start

    // Zero period and delay must behave like one. First frame has a low stop
    // bit and the next start comes on the very next tick.
    wait_drained();
    set_config(8'h00, 8'h00, 8'h01);
    phase_left = 64;
    gen_frame(8'h80, 1'b0, WHOLE_FRAME, 0, 0);
    gen_frame(8'h7F, 1'b1, WHOLE_FRAME, 0, 0);
    queue_line(ACT_READ, 1'b1);
    queue_line(ACT_READ, 1'b0);
    queue_line(ACT_READ, 1'b1);     // third read finds it empty

    // Random phases; each starts only once everything before it has drained.
    run_phase(8'd3, 8'd4, 8'h01, 80, 10, 1, 50);
    // receiver disabled while that frame is still running: it must finish
    run_phase(8'd2, 8'd3, {7'($urandom), 1'b0}, 80, 10, 1, 50);
    // fast whole frames, no reads: FIFO fills and later bytes are dropped
    run_phase(8'd0, 8'd0, 8'h01, 100, 0, 0, 760);
    // read-heavy drain down to empty
    run_phase(8'd2, 8'd1, 8'h01, 80, 55, 2, 130);
    run_phase(8'd1, 8'd0, {7'($urandom), 1'b1}, 70, 20, 3, 50);
    // longest timing; the phase ends mid-frame
    run_phase(8'd255, 8'd255, 8'h01, 80, 5, 0, 50);

    wait_drained();
    $display("Covered %0d line transactions over %0d register writes; %0d bytes read back,",
             lines_sent, cfg_writes, bytes_read);
    $display("%0d bytes dropped on a full FIFO, %0d results compared, %0d mismatches.",
             bytes_dropped, statuses_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
